// ----- hw/rtl/fbsq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbsq_pkg: shared types and constants of the frame buffer slot queue
// Slot states, command codes, result codes, register reset values and the
// decision record passed from the command stage to the address stage.
// ----------------------------------------------------------------------------
package fbsq_pkg;

  localparam int SLOT_W   = 4;
  localparam int ACTION_W = 3;
  localparam int STATUS_W = 2;
  localparam int ADDR_W   = 64;
  localparam int SPACE_W  = 32;
  localparam int PROD_W   = SLOT_W + SPACE_W;
  localparam int CFG_IDX_W = 1;

  // slot states
  localparam logic [1:0] ST_FREE     = 2'd0;
  localparam logic [1:0] ST_DEQUEUED = 2'd1;
  localparam logic [1:0] ST_QUEUED   = 2'd2;
  localparam logic [1:0] ST_ACQUIRED = 2'd3;

  // commands
  localparam logic [ACTION_W-1:0] ACT_DEQUEUE = 3'd0;
  localparam logic [ACTION_W-1:0] ACT_QUEUE   = 3'd1;
  localparam logic [ACTION_W-1:0] ACT_CANCEL  = 3'd2;
  localparam logic [ACTION_W-1:0] ACT_ACQUIRE = 3'd3;
  localparam logic [ACTION_W-1:0] ACT_RELEASE = 3'd4;

  // result codes
  localparam logic [STATUS_W-1:0] RES_OK          = 2'd0;
  localparam logic [STATUS_W-1:0] RES_NONE_QUEUED = 2'd1;
  localparam logic [STATUS_W-1:0] RES_FORCED      = 2'd2;
  localparam logic [STATUS_W-1:0] RES_RANGE       = 2'd3;

  localparam logic [SLOT_W-1:0] NO_SLOT_MARK = 4'hF;

  // configuration register indexes and reset values
  localparam logic [CFG_IDX_W-1:0] REG_BUFFER_BASE  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SLOT_SPACING = 1'd1;
  localparam logic [ADDR_W-1:0]    BASE_RESET    = 64'h0000_0000_E000_0000;
  localparam logic [SPACE_W-1:0]   SPACING_RESET = 32'h0040_0000;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   chosen_slot;
    logic                addr_zero;
    logic [SLOT_W-1:0]   cur_index;
  } fbsq_dec_t;

endpackage

// ----- hw/rtl/fbsq_cmd.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbsq_cmd: slot state table and command decision stage
// Holds the slot states and the dequeue pointer, decides each command
// combinationally and registers chosen slot, result code and scan-out slot.
// ----------------------------------------------------------------------------
module fbsq_cmd
  import fbsq_pkg::*;
#(
  parameter int SLOT_COUNT = 3
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_tvalid,
  output logic                s_tready,
  input  logic [7:0]          s_tdata,   // [2:0] action, [6:3] slot
  output logic                dec_valid,
  input  logic                dec_ready,
  output fbsq_dec_t           dec
);

  localparam int IW = $clog2(SLOT_COUNT);

  logic [1:0]          slot_status      [SLOT_COUNT];
  logic [1:0]          slot_status_next [SLOT_COUNT];
  logic [IW-1:0]       next_slot;
  logic [IW-1:0]       next_slot_next;
  fbsq_dec_t           dec_next;

  logic [ACTION_W-1:0] act;
  logic [SLOT_W-1:0]   slot_in;
  logic                in_range;
  logic                s_fire;

  logic                hi_found, lo_found, deq_found, acq_found, cur_found;
  logic [SLOT_W-1:0]   hi_idx, lo_idx, deq_idx, acq_idx, cur_idx;
  logic [SLOT_W:0]     deq_inc;
  logic                elig;

  assign act      = s_tdata[2:0];
  assign slot_in  = s_tdata[6:3];
  assign in_range = {1'b0, slot_in} < (SLOT_W+1)'(SLOT_COUNT);
  assign s_tready = !dec_valid || dec_ready;
  assign s_fire   = s_tvalid && s_tready;

  always_comb begin
    // round-robin search: lowest eligible slot at or above the pointer,
    // else lowest eligible slot overall
    hi_found  = 1'b0;
    lo_found  = 1'b0;
    acq_found = 1'b0;
    hi_idx    = '0;
    lo_idx    = '0;
    acq_idx   = '0;
    for (int k = SLOT_COUNT - 1; k >= 0; k--) begin
      elig = (slot_status[k] == ST_FREE) || (slot_status[k] == ST_ACQUIRED);
      if (elig) begin
        lo_found = 1'b1;
        lo_idx   = SLOT_W'(k);
        if (SLOT_W'(k) >= SLOT_W'(next_slot)) begin
          hi_found = 1'b1;
          hi_idx   = SLOT_W'(k);
        end
      end
      if (slot_status[k] == ST_QUEUED) begin
        acq_found = 1'b1;
        acq_idx   = SLOT_W'(k);
      end
    end
    deq_found = hi_found || lo_found;
    if (hi_found) begin
      deq_idx = hi_idx;
    end else if (lo_found) begin
      deq_idx = lo_idx;
    end else begin
      deq_idx = SLOT_W'(next_slot);
    end
    deq_inc = {1'b0, deq_idx} + (SLOT_W+1)'(1);

    for (int k = 0; k < SLOT_COUNT; k++) begin
      slot_status_next[k] = slot_status[k];
    end
    next_slot_next       = next_slot;
    dec_next.status      = RES_OK;
    dec_next.chosen_slot = slot_in;
    dec_next.addr_zero   = 1'b0;

    case (act)
      ACT_DEQUEUE: begin
        dec_next.chosen_slot = deq_idx;
        if (!deq_found) begin
          dec_next.status = RES_FORCED;
        end
        for (int k = 0; k < SLOT_COUNT; k++) begin
          if (deq_idx == SLOT_W'(k)) begin
            slot_status_next[k] = ST_DEQUEUED;
          end
        end
        next_slot_next = (deq_inc == (SLOT_W+1)'(SLOT_COUNT)) ? '0 : IW'(deq_inc);
      end
      ACT_QUEUE, ACT_CANCEL, ACT_RELEASE: begin
        if (!in_range) begin
          dec_next.status = RES_RANGE;
        end
        for (int k = 0; k < SLOT_COUNT; k++) begin
          if (in_range && slot_in == SLOT_W'(k)) begin
            slot_status_next[k] = (act == ACT_QUEUE) ? ST_QUEUED : ST_FREE;
          end
        end
      end
      ACT_ACQUIRE: begin
        if (acq_found) begin
          dec_next.chosen_slot = acq_idx;
          for (int k = 0; k < SLOT_COUNT; k++) begin
            if (acq_idx == SLOT_W'(k)) begin
              slot_status_next[k] = ST_ACQUIRED;
            end
          end
        end else begin
          dec_next.status      = RES_NONE_QUEUED;
          dec_next.chosen_slot = NO_SLOT_MARK;
          dec_next.addr_zero   = 1'b1;
        end
      end
      default: begin
        // unknown command: echo the slot, leave the state alone
      end
    endcase

    // scan-out slot after the update; slot zero gives the base address
    cur_found = 1'b0;
    cur_idx   = '0;
    for (int k = SLOT_COUNT - 1; k >= 0; k--) begin
      if (slot_status_next[k] == ST_QUEUED || slot_status_next[k] == ST_ACQUIRED) begin
        cur_found = 1'b1;
        cur_idx   = SLOT_W'(k);
      end
    end
    dec_next.cur_index = cur_found ? cur_idx : '0;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int k = 0; k < SLOT_COUNT; k++) begin
        slot_status[k] <= ST_FREE;
      end
      next_slot <= '0;
      dec_valid <= 1'b0;
    end else begin
      if (s_fire) begin
        for (int k = 0; k < SLOT_COUNT; k++) begin
          slot_status[k] <= slot_status_next[k];
        end
        next_slot <= next_slot_next;
        dec_valid <= 1'b1;
      end else if (dec_ready) begin
        dec_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      dec <= dec_next;
    end
  end

  a_ptr_range: assert property (@(posedge clk) disable iff (rst)
    SLOT_W'(next_slot) < SLOT_W'(SLOT_COUNT))
    else $error("dequeue pointer out of range");

  a_deq_result: assert property (@(posedge clk) disable iff (rst)
    s_fire && act == ACT_DEQUEUE |=> dec_valid
      && (dec.status == RES_OK || dec.status == RES_FORCED)
      && dec.chosen_slot < SLOT_W'(SLOT_COUNT))
    else $error("dequeue produced a bad decision");

  a_cur_range: assert property (@(posedge clk) disable iff (rst)
    dec_valid |-> dec.cur_index < SLOT_W'(SLOT_COUNT))
    else $error("scan-out slot out of range");

endmodule

// ----- hw/rtl/fbsq_addr.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbsq_addr: address stage and result register
// Holds the base and spacing registers, turns slot indexes into addresses
// and packs the result into the output register.
// ----------------------------------------------------------------------------
module fbsq_addr
  import fbsq_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [ADDR_W-1:0]     cfg_data,
  input  logic                  dec_valid,
  output logic                  dec_ready,
  input  fbsq_dec_t             dec,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // [1:0] status, [5:2] chosen_slot, [69:6] slot buffer address,
  // [133:70] current_address, [135:134] zero
  output logic [135:0]          m_tdata
);

  logic [ADDR_W-1:0]  buffer_base;
  logic [SPACE_W-1:0] slot_spacing;
  logic [PROD_W-1:0]  buf_prod, cur_prod;
  logic [ADDR_W-1:0]  buf_addr, cur_addr;
  logic               dec_fire;

  assign dec_ready = !m_tvalid || m_tready;
  assign dec_fire  = dec_valid && dec_ready;

  assign buf_prod = PROD_W'(dec.chosen_slot) * PROD_W'(slot_spacing);
  assign cur_prod = PROD_W'(dec.cur_index) * PROD_W'(slot_spacing);
  assign buf_addr = dec.addr_zero ? '0 : buffer_base + ADDR_W'(buf_prod);
  assign cur_addr = buffer_base + ADDR_W'(cur_prod);

  always_ff @(posedge clk) begin
    if (rst) begin
      buffer_base  <= BASE_RESET;
      slot_spacing <= SPACING_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BUFFER_BASE:  buffer_base  <= cfg_data;
        REG_SLOT_SPACING: slot_spacing <= cfg_data[SPACE_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (dec_fire) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (dec_fire) begin
      m_tdata <= {2'b00, cur_addr, buf_addr, dec.chosen_slot, dec.status};
    end
  end

  a_fill: assert property (@(posedge clk) disable iff (rst)
    dec_fire |=> m_tvalid)
    else $error("decision transfer lost");

  a_none_queued: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[1:0] == RES_NONE_QUEUED
      |-> m_tdata[5:2] == NO_SLOT_MARK && m_tdata[69:6] == '0)
    else $error("empty acquire carries a slot or address");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

endmodule

// ----- hw/rtl/frame_buffer_slot_queue_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// frame_buffer_slot_queue_unit: frame buffer slot queue
// A command passes the decision register, then the address/result register.
// Throughput: one command per cycle while the output is not stalled, set by
// the combinational slot search and state update in the command stage.
// Reset: all slots free, dequeue pointer zero, base and spacing at their
// reset values; no clearing pass, commands are taken right after reset.
// ----------------------------------------------------------------------------
module frame_buffer_slot_queue_unit
  import fbsq_pkg::*;
#(
  parameter int SLOT_COUNT = 3
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [ADDR_W-1:0]     cfg_data,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,   // [2:0] action, [6:3] slot
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // [1:0] status, [5:2] chosen_slot, [69:6] slot buffer address,
  // [133:70] current_address, [135:134] zero
  output logic [135:0]          m_tdata
);

  logic      dec_valid;
  logic      dec_ready;
  fbsq_dec_t dec;

  fbsq_cmd #(
    .SLOT_COUNT (SLOT_COUNT)
  ) u_cmd (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .dec_valid (dec_valid),
    .dec_ready (dec_ready),
    .dec       (dec)
  );

  fbsq_addr u_addr (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .dec_valid (dec_valid),
    .dec_ready (dec_ready),
    .dec       (dec),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

endmodule

// ----- verif/fbsq_slot_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fbsq_slot_checker: result checker for the frame buffer slot queue
// Tracks register writes and command transfers. Keeps its own copy of the
// slot states, dequeue pointer, base and spacing, and predicts each result.
// Compares every result transfer field by field against the oldest
// prediction.
// ----------------------------------------------------------------------------
module fbsq_slot_checker
  import fbsq_pkg::*;
#(
  parameter int SLOT_COUNT = 3
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [ADDR_W-1:0]    cfg_data,
  input  logic                 s_tvalid,
  input  logic                 s_tready,
  input  logic [7:0]           s_tdata,   // [2:0] action, [6:3] slot
  input  logic                 m_tvalid,
  input  logic                 m_tready,
  // [1:0] status, [5:2] chosen_slot, [69:6] slot buffer address,
  // [133:70] current_address, [135:134] zero
  input  logic [135:0]         m_tdata,
  output int                   fail_count,
  output int                   pending,
  output int                   result_count,
  output int                   forced_count,
  output int                   empty_acquire_count,
  output int                   range_count
);

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   chosen_slot;
    logic [ADDR_W-1:0]   buf_addr;
    logic [ADDR_W-1:0]   current_address;
  } slot_result_t;

  logic [1:0]        slot_state [SLOT_COUNT];
  int                dq_ptr;
  logic [ADDR_W-1:0] base_q;
  logic [SPACE_W-1:0] spacing_q;
  slot_result_t      expected_results [$];
  int                errors = 0;
  int                seen = 0;
  int                n_forced = 0;
  int                n_empty = 0;
  int                n_range = 0;

  function automatic logic [ADDR_W-1:0] slot_address(logic [SLOT_W-1:0] k);
    return base_q + ADDR_W'(k) * ADDR_W'(spacing_q);
  endfunction

  // lowest slot that is queued or acquired, else the base
  function automatic logic [ADDR_W-1:0] scan_out_address();
    for (int k = 0; k < SLOT_COUNT; k++) begin
      if (slot_state[k] == ST_QUEUED || slot_state[k] == ST_ACQUIRED)
        return slot_address(SLOT_W'(k));
    end
    return base_q;
  endfunction

  function automatic slot_result_t predict_command(logic [ACTION_W-1:0] action,
                                                   logic [SLOT_W-1:0] slot);
    slot_result_t res;
    logic [SLOT_W-1:0] chosen;
    logic addr_zero;
    logic found;
    int idx;
    res.status = RES_OK;
    chosen = slot;
    addr_zero = 1'b0;
    found = 1'b0;
    case (action)
      ACT_DEQUEUE: begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
          idx = (dq_ptr + i) % SLOT_COUNT;
          if (!found && (slot_state[idx] == ST_FREE || slot_state[idx] == ST_ACQUIRED)) begin
            chosen = SLOT_W'(idx);
            found = 1'b1;
          end
        end
        // nothing reusable: take the slot at the pointer anyway
        if (!found) begin
          chosen = SLOT_W'(dq_ptr);
          res.status = RES_FORCED;
        end
        slot_state[chosen] = ST_DEQUEUED;
        dq_ptr = (int'(chosen) + 1) % SLOT_COUNT;
      end
      ACT_QUEUE, ACT_CANCEL, ACT_RELEASE: begin
        if (int'(slot) < SLOT_COUNT)
          slot_state[slot] = (action == ACT_QUEUE) ? ST_QUEUED : ST_FREE;
        else
          res.status = RES_RANGE;
      end
      ACT_ACQUIRE: begin
        for (int i = 0; i < SLOT_COUNT; i++) begin
          if (!found && slot_state[i] == ST_QUEUED) begin
            chosen = SLOT_W'(i);
            found = 1'b1;
          end
        end
        if (found) begin
          slot_state[chosen] = ST_ACQUIRED;
        end else begin
          res.status = RES_NONE_QUEUED;
          chosen = NO_SLOT_MARK;
          addr_zero = 1'b1;
        end
      end
      default: ;
    endcase
    res.chosen_slot = chosen;
    res.buf_addr = addr_zero ? '0 : slot_address(chosen);
    res.current_address = scan_out_address();
    return res;
  endfunction

  function automatic void flag_field(string field, logic [ADDR_W-1:0] want,
                                     logic [ADDR_W-1:0] got);
    errors++;
    if (errors <= 10)
      $display("mismatch in %s at %0t: expected %h, got %h", field, $time, want, got);
  endfunction

  always @(posedge clk) begin
    slot_result_t want;
    slot_result_t got;
    if (rst) begin
      foreach (slot_state[k]) slot_state[k] = ST_FREE;
      dq_ptr = 0;
      base_q = BASE_RESET;
      spacing_q = SPACING_RESET;
      expected_results.delete();
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_BUFFER_BASE:  base_q = cfg_data;
          REG_SLOT_SPACING: spacing_q = cfg_data[SPACE_W-1:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        seen++;
        got.status = m_tdata[1:0];
        got.chosen_slot = m_tdata[5:2];
        got.buf_addr = m_tdata[69:6];
        got.current_address = m_tdata[133:70];
        if (expected_results.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result transfer at %0t: %h", $time, m_tdata);
        end else begin
          want = expected_results.pop_front();
          if (got.status !== want.status)
            flag_field("status", ADDR_W'(want.status), ADDR_W'(got.status));
          if (got.chosen_slot !== want.chosen_slot)
            flag_field("chosen_slot", ADDR_W'(want.chosen_slot), ADDR_W'(got.chosen_slot));
          if (got.buf_addr !== want.buf_addr)
            flag_field("buf_addr", want.buf_addr, got.buf_addr);
          if (got.current_address !== want.current_address)
            flag_field("current_address", want.current_address, got.current_address);
          if (m_tdata[135:134] !== 2'b00)
            flag_field("padding", '0, ADDR_W'(m_tdata[135:134]));
        end
      end
      if (s_tvalid && s_tready) begin
        want = predict_command(s_tdata[2:0], s_tdata[6:3]);
        case (want.status)
          RES_FORCED:      n_forced++;
          RES_NONE_QUEUED: n_empty++;
          RES_RANGE:       n_range++;
          default: ;
        endcase
        expected_results.push_back(want);
      end
    end
    fail_count <= errors;
    pending <= expected_results.size();
    result_count <= seen;
    forced_count <= n_forced;
    empty_acquire_count <= n_empty;
    range_count <= n_range;
  end

endmodule

// ----- verif/tb_frame_buffer_slot_queue_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_frame_buffer_slot_queue_unit: testbench of the frame buffer slot queue
// Runs a directed command sequence at reset settings, then random frame
// lifecycles and noise commands under six base/spacing settings and three
// handshake pacing modes. A checker beside the block predicts and compares.
// ----------------------------------------------------------------------------
module tb_frame_buffer_slot_queue_unit;
  import fbsq_pkg::*;

  localparam int SLOTS = 3;
  localparam int LATENCY = 2;
  localparam int QUIET_LIMIT = 5000;
  localparam int PHASES = 6;
  localparam int PHASE_ITEMS = 221;

  logic                 clk;
  logic                 rst = 1'b1;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [ADDR_W-1:0]    cfg_data = '0;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  logic [7:0]           s_tdata = '0;   // [2:0] action, [6:3] slot
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  // [1:0] status, [5:2] chosen_slot, [69:6] slot buffer address,
  // [133:70] current_address, [135:134] zero
  logic [135:0]         m_tdata;

  int fail_count;
  int pending;
  int result_count;
  int forced_count;
  int empty_acquire_count;
  int range_count;

  int send_idle_pct = 0;
  int stall_pct = 0;
  int commands_sent = 0;
  int quiet_cycles = 0;

  frame_buffer_slot_queue_unit #(.SLOT_COUNT(SLOTS)) uut (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
  );

  fbsq_slot_checker #(.SLOT_COUNT(SLOTS)) u_checker (
    .clk(clk), .rst(rst),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
    .fail_count(fail_count), .pending(pending), .result_count(result_count),
    .forced_count(forced_count), .empty_acquire_count(empty_acquire_count),
    .range_count(range_count)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    m_tready <= ($urandom_range(99) >= stall_pct);
  end

  // end the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no transfer for %0d cycles", QUIET_LIMIT);
        $display("tb_frame_buffer_slot_queue_unit failed");
        $finish;
      end
    end
  end

  task automatic send_command(logic [ACTION_W-1:0] action, logic [SLOT_W-1:0] slot);
    while ($urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {1'b0, slot, action};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    commands_sent++;
  endtask

  // hold the sender until every result is back, then let the pipe settle
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  task automatic write_config(logic [ADDR_W-1:0] base, logic [SPACE_W-1:0] spacing);
    cfg_we <= 1'b1;
    cfg_index <= REG_BUFFER_BASE;
    cfg_data <= base;
    @(posedge clk);
    cfg_index <= REG_SLOT_SPACING;
    cfg_data <= ADDR_W'(spacing);
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_directed();
    send_command(ACT_ACQUIRE, 4'd0);      // nothing queued yet
    send_command(ACT_RELEASE, 4'd0);
    send_command(ACT_DEQUEUE, 4'd0);
    send_command(ACT_DEQUEUE, 4'd5);
    send_command(ACT_DEQUEUE, 4'd15);
    send_command(ACT_DEQUEUE, 4'd0);      // all dequeued: forced reuse
    send_command(ACT_QUEUE, 4'd0);
    send_command(ACT_QUEUE, 4'd1);
    send_command(ACT_QUEUE, 4'd15);       // out of range
    send_command(ACT_CANCEL, 4'd3);       // just past the last slot
    send_command(ACT_RELEASE, 4'd8);
    send_command(ACT_ACQUIRE, 4'd7);
    send_command(ACT_ACQUIRE, 4'd0);
    send_command(ACT_ACQUIRE, 4'd0);      // queue empty again
    send_command(ACT_DEQUEUE, 4'd0);      // reuses an acquired slot
    send_command(ACT_QUEUE, 4'd2);
    send_command(ACT_CANCEL, 4'd2);
    send_command(ACT_RELEASE, 4'd0);
    send_command(3'd5, 4'd9);             // undefined actions echo the slot
    send_command(3'd6, 4'd0);
    send_command(3'd7, 4'd15);
    send_command(ACT_QUEUE, 4'd2);
    send_command(ACT_ACQUIRE, 4'd10);
    send_command(ACT_DEQUEUE, 4'd6);
  endtask

  // mostly frame lifecycles on valid slots, the rest raw command noise
  task automatic run_random(int count);
    int target;
    logic [SLOT_W-1:0] s;
    target = commands_sent + count;
    while (commands_sent < target) begin
      if ($urandom_range(99) < 70) begin
        s = SLOT_W'($urandom_range(SLOTS - 1));
        send_command(ACT_DEQUEUE, SLOT_W'($urandom));
        send_command(ACT_QUEUE, s);
        if ($urandom_range(1) == 1)
          send_command(ACT_ACQUIRE, SLOT_W'($urandom));
        if ($urandom_range(3) == 0)
          send_command(ACT_CANCEL, SLOT_W'($urandom_range(SLOTS - 1)));
        else
          send_command(ACT_RELEASE, SLOT_W'($urandom_range(SLOTS - 1)));
      end else begin
        send_command(ACTION_W'($urandom), SLOT_W'($urandom));
      end
    end
  endtask

  initial begin
    logic [ADDR_W-1:0]  bases [PHASES];
    logic [SPACE_W-1:0] spacings [PHASES];
    bases[0] = '0;
    spacings[0] = '0;
    bases[1] = '1;
    spacings[1] = '1;
    bases[2] = {$urandom, $urandom};
    spacings[2] = $urandom;
    bases[3] = BASE_RESET;
    spacings[3] = SPACING_RESET;
    bases[4] = 64'hFFFF_FFFF_0000_0000 | ADDR_W'($urandom);
    spacings[4] = 32'h8000_0000 | $urandom;
    bases[5] = {$urandom, $urandom};
    spacings[5] = SPACE_W'($urandom_range(16));

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    run_directed();
    drain_results();

    for (int p = 0; p < PHASES; p++) begin
      case (p / 2)
        0: begin send_idle_pct = 20; stall_pct <= 73; end
        1: begin send_idle_pct = 73; stall_pct <= 20; end
        default: begin send_idle_pct = 0; stall_pct <= 0; end
      endcase
      write_config(bases[p], spacings[p]);
      run_random(PHASE_ITEMS / 2);
      drain_results();
      run_random(PHASE_ITEMS - PHASE_ITEMS / 2);
      drain_results();
    end

    repeat (LATENCY + 8) @(posedge clk);
    $display("ran %0d commands, %0d results checked, over %0d base/spacing settings",
             commands_sent, result_count, PHASES + 1);
    $display("hit %0d forced dequeues, %0d empty acquires, %0d out-of-range slots",
             forced_count, empty_acquire_count, range_count);
    if (fail_count == 0)
      $display("tb_frame_buffer_slot_queue_unit passed");
    else
      $display("tb_frame_buffer_slot_queue_unit failed");
    $finish;
  end

endmodule
